// ===== src/voxel_grid_bitmap_splatter_core_assert.svh =====
// Assertion macros for the checker file of the splatter core.
// No dependencies; included by bare file name.
`ifndef VOXEL_GRID_BITMAP_SPLATTER_CORE_ASSERT_SVH
`define VOXEL_GRID_BITMAP_SPLATTER_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define VGBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vgbs check failed");

// Next-cycle implication.
`define VGBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vgbs check failed");

`endif

// ===== src/vgbs_pkg.sv =====
// Shared types, codes, defaults and saturating vector math for the splatter core.
// No dependencies.
package vgbs_pkg;

  localparam int DEF_MAP_WIDTH      = 64;
  localparam int DEF_MAP_HEIGHT     = 64;
  localparam int DEF_MAP_DEPTH      = 64;
  localparam int DEF_MAX_ENTITY_DIM = 255;

  localparam int WORD_BITS   = 64;
  localparam int DIRTY_MIN_W = 16;
  localparam int DIRTY_MAX_W = 15;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_VOXEL = 2'd1,
    ACT_READ  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  localparam logic [2:0] SEL_ORIGIN = 3'd0;
  localparam logic [2:0] SEL_STEP_I = 3'd1;
  localparam logic [2:0] SEL_STEP_J = 3'd2;
  localparam logic [2:0] SEL_STEP_K = 3'd3;
  localparam logic [2:0] SEL_DIMS   = 3'd4;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec3_t;

  // one command per committed beat
  typedef struct packed {
    logic       load_vec;
    logic [1:0] vec_idx;
    logic       load_dim;
    logic       step;
    vec3_t      vec;
  } walk_cmd_t;

  typedef struct packed {
    vec3_t pos;
    logic  pending;
    logic  pending_nxt;
  } walk_stat_t;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    return s[31:0];
  endfunction

  function automatic vec3_t vec_add(input vec3_t a, input vec3_t b);
    vec3_t r;
    r.x = sat_add(a.x, b.x);
    r.y = sat_add(a.y, b.y);
    r.z = sat_add(a.z, b.z);
    return r;
  endfunction

endpackage

// ===== src/vgbs_if.sv =====
// Valid/ready channel interfaces of the splatter core: input, result, config.
// Depends on nothing.
interface vgbs_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [2:0]         vector_select;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] vec_z;
  logic [7:0]         voxel_flags;
  logic [11:0]        word_index;

  modport source (output valid, action, vector_select, vec_x, vec_y, vec_z,
                  voxel_flags, word_index, input ready);
  modport sink   (input valid, action, vector_select, vec_x, vec_y, vec_z,
                  voxel_flags, word_index, output ready);
endinterface

interface vgbs_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] map_word;
  logic        bit_set;
  logic        entity_done;
  logic [15:0] dirty_min;
  logic [14:0] dirty_max;

  modport source (output valid, map_word, bit_set, entity_done, dirty_min, dirty_max,
                  input ready);
  modport sink   (input valid, map_word, bit_set, entity_done, dirty_min, dirty_max,
                  output ready);
endinterface

interface vgbs_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== src/vgbs_ram.sv =====
// Generic single-port-write, single-port-read RAM with bit write enables.
// Registered read data. No dependencies.
module vgbs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wmask,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      for (int i = 0; i < WIDTH; i++) begin
        if (wmask[i]) begin
          mem[waddr][i] <= wdata[i];
        end
      end
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/vgbs_walk.sv =====
// Entity walker: step vectors, extents, loop counters and the incremental position.
// Depends on vgbs_pkg.
module vgbs_walk #(
  parameter int MAX_ENTITY_DIM = vgbs_pkg::DEF_MAX_ENTITY_DIM,
  localparam int DIM_W         = $clog2(MAX_ENTITY_DIM + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  vgbs_pkg::walk_cmd_t  cmd,
  output vgbs_pkg::walk_stat_t stat
);

  // 0 origin, 1 step i, 2 step j, 3 step k
  vgbs_pkg::vec3_t vec_r [4];
  vgbs_pkg::vec3_t vec_nxt [4];
  logic [DIM_W-1:0] ext_r [3];
  logic [DIM_W-1:0] ext_nxt [3];
  logic [DIM_W-1:0] cnt_i_r, cnt_j_r, cnt_k_r;
  logic [DIM_W-1:0] cnt_i_nxt, cnt_j_nxt, cnt_k_nxt;
  vgbs_pkg::vec3_t  walk_r, row_r, plane_r;
  vgbs_pkg::vec3_t  walk_nxt, row_nxt, plane_nxt;
  vgbs_pkg::vec3_t  origin_new, row_step, plane_step;
  logic [DIM_W-1:0] i_inc, j_inc;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic signed [31:0] v);
    if (v < 0) begin
      return '0;
    end else if (v > $signed(32'(MAX_ENTITY_DIM))) begin
      return DIM_W'(MAX_ENTITY_DIM);
    end
    return v[DIM_W-1:0];
  endfunction

  function automatic logic is_pending(input logic [DIM_W-1:0] e0, input logic [DIM_W-1:0] e1,
                                      input logic [DIM_W-1:0] e2, input logic [DIM_W-1:0] k);
    return (|e0) && (|e1) && (|e2) && (k < e2);
  endfunction

  always_comb begin
    vec_nxt    = vec_r;
    ext_nxt    = ext_r;
    cnt_i_nxt  = cnt_i_r;
    cnt_j_nxt  = cnt_j_r;
    cnt_k_nxt  = cnt_k_r;
    walk_nxt   = walk_r;
    row_nxt    = row_r;
    plane_nxt  = plane_r;
    origin_new = (cmd.load_vec && cmd.vec_idx == 2'd0) ? cmd.vec : vec_r[0];
    i_inc      = DIM_W'(cnt_i_r + 1'b1);
    j_inc      = DIM_W'(cnt_j_r + 1'b1);
    row_step   = vgbs_pkg::vec_add(row_r, vec_r[2]);
    plane_step = vgbs_pkg::vec_add(plane_r, vec_r[3]);

    if (cmd.load_vec) begin
      vec_nxt[cmd.vec_idx] = cmd.vec;
    end
    if (cmd.load_dim) begin
      ext_nxt[0] = clamp_dim(cmd.vec.x);
      ext_nxt[1] = clamp_dim(cmd.vec.y);
      ext_nxt[2] = clamp_dim(cmd.vec.z);
    end

    if (cmd.load_vec || cmd.load_dim) begin
      // any load restarts the walk at the origin
      cnt_i_nxt = '0;
      cnt_j_nxt = '0;
      cnt_k_nxt = '0;
      walk_nxt  = origin_new;
      row_nxt   = origin_new;
      plane_nxt = origin_new;
    end else if (cmd.step) begin
      if (i_inc < ext_r[0]) begin
        cnt_i_nxt = i_inc;
        walk_nxt  = vgbs_pkg::vec_add(walk_r, vec_r[1]);
      end else if (j_inc < ext_r[1]) begin
        // next row
        cnt_i_nxt = '0;
        cnt_j_nxt = j_inc;
        row_nxt   = row_step;
        walk_nxt  = row_step;
      end else begin
        // next plane
        cnt_i_nxt = '0;
        cnt_j_nxt = '0;
        cnt_k_nxt = DIM_W'(cnt_k_r + 1'b1);
        plane_nxt = plane_step;
        row_nxt   = plane_step;
        walk_nxt  = plane_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < 4; n++) begin
        vec_r[n] <= '0;
      end
      for (int n = 0; n < 3; n++) begin
        ext_r[n] <= '0;
      end
      cnt_i_r <= '0;
      cnt_j_r <= '0;
      cnt_k_r <= '0;
      walk_r  <= '0;
      row_r   <= '0;
      plane_r <= '0;
    end else begin
      vec_r   <= vec_nxt;
      ext_r   <= ext_nxt;
      cnt_i_r <= cnt_i_nxt;
      cnt_j_r <= cnt_j_nxt;
      cnt_k_r <= cnt_k_nxt;
      walk_r  <= walk_nxt;
      row_r   <= row_nxt;
      plane_r <= plane_nxt;
    end
  end

  assign stat.pos         = walk_r;
  assign stat.pending     = is_pending(ext_r[0], ext_r[1], ext_r[2], cnt_k_r);
  assign stat.pending_nxt = is_pending(ext_nxt[0], ext_nxt[1], ext_nxt[2], cnt_k_nxt);

endmodule

// ===== src/vgbs_addr.sv =====
// Inside test and bitmap address generation for a Q16.16 walk position.
// Depends on vgbs_pkg.
module vgbs_addr #(
  parameter int MAP_WIDTH  = vgbs_pkg::DEF_MAP_WIDTH,
  parameter int MAP_HEIGHT = vgbs_pkg::DEF_MAP_HEIGHT,
  parameter int MAP_DEPTH  = vgbs_pkg::DEF_MAP_DEPTH,
  localparam int BIT_W     = $clog2(MAP_WIDTH * MAP_HEIGHT * MAP_DEPTH),
  localparam int WORD_AW   = BIT_W - 6,
  localparam int BYTE_W    = BIT_W - 3
) (
  input  vgbs_pkg::vec3_t     pos,
  output logic                in_map,
  output logic [WORD_AW-1:0]  word_addr,
  output logic [5:0]          bit_ofs,
  output logic [BYTE_W-1:0]   byte_idx
);

  localparam int X_W = $clog2(MAP_WIDTH);
  localparam int Y_W = $clog2(MAP_HEIGHT);
  localparam int Z_W = $clog2(MAP_DEPTH);

  logic [15:0]      cx, cy, cz;
  logic             in_x, in_y, in_z;
  logic [BIT_W-1:0] bit_idx;

  assign cx = pos.x[31:16];
  assign cy = pos.y[31:16];
  assign cz = pos.z[31:16];

  assign in_x = !pos.x[31] && (cx < 16'(MAP_WIDTH));
  assign in_y = !pos.y[31] && (cy < 16'(MAP_HEIGHT));
  assign in_z = !pos.z[31] && (cz < 16'(MAP_DEPTH));
  assign in_map = in_x && in_y && in_z;

  // b = (z * H + y) * W + x
  assign bit_idx = (BIT_W'(cz[Z_W-1:0]) * BIT_W'(MAP_HEIGHT) + BIT_W'(cy[Y_W-1:0]))
                   * BIT_W'(MAP_WIDTH) + BIT_W'(cx[X_W-1:0]);

  assign word_addr = bit_idx[BIT_W-1:6];
  assign bit_ofs   = bit_idx[5:0];
  assign byte_idx  = bit_idx[BIT_W-1:3];

endmodule

// ===== src/voxel_grid_bitmap_splatter_core.sv =====
// Top level of the voxel grid bitmap splatter: input stage, walker, addressing,
// occupancy RAM, dirty range and result register. Depends on vgbs_pkg, vgbs_if,
// vgbs_ram, vgbs_walk and vgbs_addr.
//
//  channel | dir | handshake       | beat payload
//  --------+-----+-----------------+-------------------------------------------------
//  in_ch   | in  | valid / ready   | action, vector_select, vec_x/y/z, flags, word_index
//  out_ch  | out | valid / ready   | map_word, bit_set, entity_done, dirty_min/max
//  cfg_ch  | in  | valid / ready=1 | occupied_mask
//
// One beat per cycle in, one result beat per cycle out while nothing stalls; a result
// passes the input register, the commit (RAM read / state) and the result register.
// A clear-map beat blocks input while it sits in the input register, then for the
// RAM sweep, one word per cycle. After reset the same sweep runs before the first
// beat is taken; config writes are taken throughout. A stalled result register
// stalls the whole pipe.
module voxel_grid_bitmap_splatter_core #(
  parameter int MAP_WIDTH      = vgbs_pkg::DEF_MAP_WIDTH,
  parameter int MAP_HEIGHT     = vgbs_pkg::DEF_MAP_HEIGHT,
  parameter int MAP_DEPTH      = vgbs_pkg::DEF_MAP_DEPTH,
  parameter int MAX_ENTITY_DIM = vgbs_pkg::DEF_MAX_ENTITY_DIM
) (
  input logic         clk,
  input logic         rst_n,
  vgbs_in_if.sink     in_ch,
  vgbs_out_if.source  out_ch,
  vgbs_cfg_if.sink    cfg_ch
);

  localparam int MAP_BITS  = MAP_WIDTH * MAP_HEIGHT * MAP_DEPTH;
  localparam int MAP_WORDS = MAP_BITS / vgbs_pkg::WORD_BITS;
  localparam int MAP_BYTES = MAP_BITS / 8;
  localparam int BIT_W     = $clog2(MAP_BITS);
  localparam int WORD_AW   = BIT_W - 6;
  localparam int BYTE_W    = BIT_W - 3;
  localparam int RAM_DEPTH = 1 << WORD_AW;

  // ---------------- pipeline control ----------------
  logic adv;        // result register can take a new beat
  logic commit;     // stage-1 beat updates state this cycle
  logic s1_v_r, s2_v_r, out_v_r;
  logic clear_hold;

  // stage-1 (input register) payload
  vgbs_pkg::action_t  s1_action_r;
  logic [2:0]         s1_sel_r;
  vgbs_pkg::vec3_t    s1_vec_r;
  logic [7:0]         s1_flags_r;
  logic [11:0]        s1_widx_r;

  // configuration
  logic [7:0] occ_mask_r;

  // sweep of the occupancy RAM
  logic               sweep_r;
  logic [WORD_AW-1:0] sweep_cnt_r;

  // walker / addressing
  vgbs_pkg::walk_cmd_t  wcmd;
  vgbs_pkg::walk_stat_t wstat;
  logic                 in_map;
  logic [WORD_AW-1:0]   splat_addr;
  logic [5:0]           splat_bit;
  logic [BYTE_W-1:0]    splat_byte;
  logic                 is_load, occupied, splat;

  // dirty range
  logic [BYTE_W:0]   dirty_low_r, dirty_low_nxt;
  logic [BYTE_W-1:0] dirty_high_r, dirty_high_nxt;

  // RAM port signals
  logic                ram_we, ram_re;
  logic [WORD_AW-1:0]  ram_waddr, ram_raddr;
  logic [63:0]         ram_wmask, ram_wdata, ram_rdata;
  logic [31:0]         widx_ext;
  logic                read_ok;

  // stage-2 and result registers
  logic        s2_bit_set_r, s2_done_r, s2_read_ok_r;
  logic [63:0] out_word_r;
  logic        out_bit_set_r, out_done_r;
  logic [15:0] out_dmin_r;
  logic [14:0] out_dmax_r;
  logic [31:0] dmin_ext, dmax_ext;

  assign adv        = !out_v_r || out_ch.ready;
  assign commit     = adv && s1_v_r;
  // hold off new beats while a clear waits in stage 1 or the sweep runs
  assign clear_hold = sweep_r || (s1_v_r && s1_action_r == vgbs_pkg::ACT_CLEAR);
  assign in_ch.ready = adv && !clear_hold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_ch.valid && in_ch.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_action_r <= vgbs_pkg::action_t'(in_ch.action);
      s1_sel_r    <= in_ch.vector_select;
      s1_vec_r    <= '{x: in_ch.vec_x, y: in_ch.vec_y, z: in_ch.vec_z};
      s1_flags_r  <= in_ch.voxel_flags;
      s1_widx_r   <= in_ch.word_index;
    end
  end

  // ---------------- configuration ----------------
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_mask_r <= 8'd1;
    end else if (cfg_ch.valid) begin
      occ_mask_r <= cfg_ch.data;
    end
  end

  // ---------------- walker and addressing ----------------
  assign is_load  = s1_action_r == vgbs_pkg::ACT_LOAD;
  assign occupied = |(s1_flags_r & occ_mask_r);

  always_comb begin
    wcmd.load_vec = commit && is_load &&
                    (s1_sel_r inside {[vgbs_pkg::SEL_ORIGIN:vgbs_pkg::SEL_STEP_K]});
    wcmd.vec_idx  = s1_sel_r[1:0];
    wcmd.load_dim = commit && is_load && (s1_sel_r == vgbs_pkg::SEL_DIMS);
    wcmd.step     = commit && (s1_action_r == vgbs_pkg::ACT_VOXEL) && wstat.pending;
    wcmd.vec      = s1_vec_r;
  end

  vgbs_walk #(
    .MAX_ENTITY_DIM (MAX_ENTITY_DIM)
  ) u_walk (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (wcmd),
    .stat (wstat)
  );

  vgbs_addr #(
    .MAP_WIDTH (MAP_WIDTH),
    .MAP_HEIGHT(MAP_HEIGHT),
    .MAP_DEPTH (MAP_DEPTH)
  ) u_addr (
    .pos      (wstat.pos),
    .in_map   (in_map),
    .word_addr(splat_addr),
    .bit_ofs  (splat_bit),
    .byte_idx (splat_byte)
  );

  // bit set only for an occupied voxel inside the map
  assign splat = wcmd.step && occupied && in_map;

  // ---------------- dirty byte range ----------------
  always_comb begin
    dirty_low_nxt  = dirty_low_r;
    dirty_high_nxt = dirty_high_r;
    if (commit && s1_action_r == vgbs_pkg::ACT_CLEAR) begin
      dirty_low_nxt  = (BYTE_W + 1)'(MAP_BYTES);
      dirty_high_nxt = '0;
    end else if (splat) begin
      if ({1'b0, splat_byte} < dirty_low_r) begin
        dirty_low_nxt = {1'b0, splat_byte};
      end
      if (splat_byte > dirty_high_r) begin
        dirty_high_nxt = splat_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dirty_low_r  <= (BYTE_W + 1)'(MAP_BYTES);
      dirty_high_r <= '0;
    end else begin
      dirty_low_r  <= dirty_low_nxt;
      dirty_high_r <= dirty_high_nxt;
    end
  end

  // ---------------- occupancy RAM sweep ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r     <= 1'b1;
      sweep_cnt_r <= '0;
    end else if (sweep_r) begin
      sweep_cnt_r <= WORD_AW'(sweep_cnt_r + 1'b1);
      if (&sweep_cnt_r) begin
        sweep_r <= 1'b0;
      end
    end else if (commit && s1_action_r == vgbs_pkg::ACT_CLEAR) begin
      sweep_r     <= 1'b1;
      sweep_cnt_r <= '0;
    end
  end

  // ---------------- occupancy RAM ----------------
  // single-bit writes for splats, whole zero words for the sweep
  assign ram_we    = sweep_r || splat;
  assign ram_waddr = sweep_r ? sweep_cnt_r : splat_addr;
  assign ram_wmask = sweep_r ? '1 : (64'd1 << splat_bit);
  assign ram_wdata = sweep_r ? '0 : '1;

  // read port holds its data while the result side stalls
  assign widx_ext  = 32'(s1_widx_r);
  assign ram_re    = commit;
  assign ram_raddr = widx_ext[WORD_AW-1:0];
  assign read_ok   = (s1_action_r == vgbs_pkg::ACT_READ) && (widx_ext < 32'(MAP_WORDS));

  vgbs_ram #(
    .WIDTH(vgbs_pkg::WORD_BITS),
    .DEPTH(RAM_DEPTH)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wmask(ram_wmask),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // ---------------- stage 2 ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      s2_bit_set_r <= splat;
      s2_done_r    <= !wstat.pending_nxt;
      s2_read_ok_r <= read_ok;
    end
  end

  // ---------------- result register ----------------
  // dirty_*_r still shows the stage-2 beat's state here: the next beat's
  // update lands on the same edge that this register captures.
  assign dmin_ext = 32'(dirty_low_r);
  assign dmax_ext = 32'(dirty_high_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_v_r) begin
      out_word_r    <= s2_read_ok_r ? ram_rdata : '0;
      out_bit_set_r <= s2_bit_set_r;
      out_done_r    <= s2_done_r;
      out_dmin_r    <= dmin_ext[vgbs_pkg::DIRTY_MIN_W-1:0];
      out_dmax_r    <= dmax_ext[vgbs_pkg::DIRTY_MAX_W-1:0];
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.map_word    = out_word_r;
  assign out_ch.bit_set     = out_bit_set_r;
  assign out_ch.entity_done = out_done_r;
  assign out_ch.dirty_min   = out_dmin_r;
  assign out_ch.dirty_max   = out_dmax_r;

endmodule

// ===== src/vgbs_chk.sv =====
// Port-level checker for the splatter core and its bind to the top level.
// Depends on voxel_grid_bitmap_splatter_core_assert.svh.
`include "voxel_grid_bitmap_splatter_core_assert.svh"

module vgbs_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_map_word,
  input logic        out_bit_set
);

  // result beat stays up until taken
  `VGBS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // a voxel beat never carries a map word
  `VGBS_ASSERT_IMP(a_set_no_word, clk, rst_n, out_valid && out_bit_set, out_map_word == 64'd0)

  // the RAM sweep after reset keeps the input closed
  `VGBS_ASSERT_IMP(a_reset_sweep, clk, rst_n, $rose(rst_n), !in_ready)

endmodule

bind voxel_grid_bitmap_splatter_core vgbs_chk u_vgbs_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_map_word(out_ch.map_word),
  .out_bit_set (out_ch.bit_set)
);

// ===== sim/voxel_grid_bitmap_splatter_core_tb.sv =====
// Self-checking bench for voxel_grid_bitmap_splatter_core: a bit-exact splat predictor
// scores every result beat, mostly under random source gaps and sink stalls.
// Depends on vgbs_pkg, vgbs_if and the core RTL.
module voxel_grid_bitmap_splatter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // ---------------------------------------------------------------------------
  // Map geometry (default core parameters) and run limits
  // ---------------------------------------------------------------------------
  localparam int MAP_W     = vgbs_pkg::DEF_MAP_WIDTH;
  localparam int MAP_H     = vgbs_pkg::DEF_MAP_HEIGHT;
  localparam int MAP_D     = vgbs_pkg::DEF_MAP_DEPTH;
  localparam int MAX_DIM   = vgbs_pkg::DEF_MAX_ENTITY_DIM;
  localparam int MAP_BYTES = MAP_W * MAP_H * MAP_D / 8;
  localparam int MAP_WORDS = MAP_W * MAP_H * MAP_D / vgbs_pkg::WORD_BITS;

  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  // The reset sweep and each clear sweep the whole RAM; everything else is small.
  localparam int CYCLE_LIMIT  = 500000;
  localparam int SETTLE_TICKS = 12;
  localparam int PHASE_BEATS  = 90;

  // Occupied-mask plan for the random phases; the middle entry is redrawn.
  localparam logic [7:0] MASK_PLAN [5] = '{8'hFF, 8'h00, 8'h5A, 8'h80, 8'h01};

  typedef struct {
    vgbs_pkg::action_t  act;
    logic [2:0]         sel;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic [7:0]         flags;
    logic [11:0]        widx;
  } splat_cmd_t;

  typedef struct packed {
    logic [63:0]                      map_word;
    logic                             bit_set;
    logic                             entity_done;
    logic [vgbs_pkg::DIRTY_MIN_W-1:0] dirty_min;
    logic [vgbs_pkg::DIRTY_MAX_W-1:0] dirty_max;
  } splat_res_t;

  // ---------------------------------------------------------------------------
  // Clock, reset, channels, core
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  vgbs_in_if  in_if ();
  vgbs_out_if out_if ();
  vgbs_cfg_if cfg_if ();

  voxel_grid_bitmap_splatter_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: occupancy map, dirty byte range, entity walk
  // ---------------------------------------------------------------------------
  logic [63:0]     occ_map [MAP_WORDS];
  int unsigned     dirt_lo, dirt_hi;
  vgbs_pkg::vec3_t ent_vec [4];      // origin, step i, step j, step k
  vgbs_pkg::vec3_t row_pos, plane_pos, walk_pos;
  int unsigned     cnt_i, cnt_j, cnt_k;
  int unsigned     extent [3];       // stride, pitch, depth
  logic [7:0]      occ_mask;

  // Q16.16 add that clips to the signed 32-bit range instead of wrapping.
  function automatic logic signed [31:0] add_clip(logic signed [31:0] a,
                                                  logic signed [31:0] b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > Q_MAX) s = Q_MAX;
    if (s < Q_MIN) s = Q_MIN;
    return s[31:0];
  endfunction

  function automatic vgbs_pkg::vec3_t vstep(vgbs_pkg::vec3_t a, vgbs_pkg::vec3_t b);
    vgbs_pkg::vec3_t r;
    r.x = add_clip(a.x, b.x);
    r.y = add_clip(a.y, b.y);
    r.z = add_clip(a.z, b.z);
    return r;
  endfunction

  function automatic int unsigned dim_clip(logic signed [31:0] v);
    if (v < 0) return 0;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic bit walk_open();
    return extent[0] != 0 && extent[1] != 0 && extent[2] != 0 && cnt_k < extent[2];
  endfunction

  // Any load puts the walk back at the origin.
  function automatic void walk_restart();
    cnt_i     = 0;
    cnt_j     = 0;
    cnt_k     = 0;
    walk_pos  = ent_vec[0];
    row_pos   = ent_vec[0];
    plane_pos = ent_vec[0];
  endfunction

  function automatic void map_wipe();
    foreach (occ_map[w]) occ_map[w] = '0;
    dirt_lo = MAP_BYTES;
    dirt_hi = 0;
  endfunction

  // Sets the bit under the walk position when it falls inside the map.
  function automatic bit try_splat();
    logic signed [31:0] p [3];
    int unsigned        crd [3];
    int unsigned        lim [3];
    int unsigned        b, byte_i;
    p   = '{walk_pos.x, walk_pos.y, walk_pos.z};
    lim = '{MAP_W, MAP_H, MAP_D};
    for (int a = 0; a < 3; a++) begin
      if (p[a] < 0) return 1'b0;
      crd[a] = p[a] >>> 16;
      if (crd[a] >= lim[a]) return 1'b0;
    end
    b = (crd[2] * MAP_H + crd[1]) * MAP_W + crd[0];
    occ_map[b / vgbs_pkg::WORD_BITS][b % vgbs_pkg::WORD_BITS] = 1'b1;
    byte_i = b / 8;
    if (byte_i < dirt_lo) dirt_lo = byte_i;
    if (byte_i > dirt_hi) dirt_hi = byte_i;
    return 1'b1;
  endfunction

  // x steps every voxel; a finished row restarts from the row start moved by
  // step j, a finished plane from the plane start moved by step k.
  function automatic void walk_advance();
    cnt_i++;
    walk_pos = vstep(walk_pos, ent_vec[1]);
    if (cnt_i < extent[0]) return;
    cnt_i = 0;
    cnt_j++;
    row_pos = vstep(row_pos, ent_vec[2]);
    if (cnt_j >= extent[1]) begin
      cnt_j     = 0;
      cnt_k++;
      plane_pos = vstep(plane_pos, ent_vec[3]);
      row_pos   = plane_pos;
    end
    walk_pos = row_pos;
  endfunction

  function automatic splat_res_t predict_beat(splat_cmd_t c);
    splat_res_t r;
    r = '0;
    case (c.act)
      vgbs_pkg::ACT_LOAD: begin
        if (c.sel <= vgbs_pkg::SEL_STEP_K) begin
          ent_vec[c.sel[1:0]] = '{x: c.vx, y: c.vy, z: c.vz};
          walk_restart();
        end else if (c.sel == vgbs_pkg::SEL_DIMS) begin
          extent[0] = dim_clip(c.vx);
          extent[1] = dim_clip(c.vy);
          extent[2] = dim_clip(c.vz);
          walk_restart();
        end
        // unknown selects leave everything alone
      end
      vgbs_pkg::ACT_VOXEL: begin
        if (walk_open()) begin
          if ((c.flags & occ_mask) != 0) r.bit_set = try_splat();
          walk_advance();
        end
      end
      vgbs_pkg::ACT_READ: begin
        if (c.widx < MAP_WORDS) r.map_word = occ_map[c.widx];
      end
      default: map_wipe();  // clear keeps the walk
    endcase
    r.entity_done = !walk_open();
    r.dirty_min   = dirt_lo[vgbs_pkg::DIRTY_MIN_W-1:0];
    r.dirty_max   = dirt_hi[vgbs_pkg::DIRTY_MAX_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus queue and generator bookkeeping
  // ---------------------------------------------------------------------------
  splat_cmd_t  cmd_q [$];
  splat_res_t  pred_q [$];
  splat_cmd_t  cur_cmd;
  logic        in_taken;
  bit          calm;           // no gaps or stalls once set
  int          send_burst, send_quiet, recv_burst, recv_quiet;
  int          fail_cnt, n_checked, n_beats, n_loads, n_voxels, n_reads, n_clears;
  int          n_bits, n_masks;
  longint      gen_total, gen_left;  // voxels the generator believes are pending
  int          n_real;               // beats that are not simply ignored

  function automatic int rnd_int(int lo, int hi);
    return lo + int'($urandom_range(32'(hi - lo)));
  endfunction

  // Fields that an action does not use still get random values.
  function automatic splat_cmd_t rand_cmd();
    splat_cmd_t c;
    c.act   = vgbs_pkg::action_t'($urandom_range(0, 3));
    c.sel   = 3'($urandom_range(0, 7));
    c.vx    = $urandom;
    c.vy    = $urandom;
    c.vz    = $urandom;
    c.flags = 8'($urandom_range(0, 255));
    c.widx  = 12'($urandom_range(0, 4095));
    return c;
  endfunction

  task automatic push_cmd(splat_cmd_t c);
    case (c.act)
      vgbs_pkg::ACT_LOAD: begin
        if (c.sel == vgbs_pkg::SEL_DIMS)
          gen_total = longint'(dim_clip(c.vx)) * dim_clip(c.vy) * dim_clip(c.vz);
        if (c.sel <= vgbs_pkg::SEL_DIMS) begin
          gen_left = gen_total;
          n_real++;
        end
      end
      vgbs_pkg::ACT_VOXEL: begin
        if (gen_left > 0) begin
          gen_left--;
          n_real++;
        end
      end
      default: n_real++;
    endcase
    cmd_q.push_back(c);
  endtask

  task automatic push_load(logic [2:0] sel, logic signed [31:0] x, logic signed [31:0] y,
                           logic signed [31:0] z);
    splat_cmd_t c;
    c     = rand_cmd();
    c.act = vgbs_pkg::ACT_LOAD;
    c.sel = sel;
    c.vx  = x;
    c.vy  = y;
    c.vz  = z;
    push_cmd(c);
  endtask

  task automatic push_voxel(logic [7:0] flags);
    splat_cmd_t c;
    c       = rand_cmd();
    c.act   = vgbs_pkg::ACT_VOXEL;
    c.flags = flags;
    push_cmd(c);
  endtask

  task automatic push_read(logic [11:0] widx);
    splat_cmd_t c;
    c      = rand_cmd();
    c.act  = vgbs_pkg::ACT_READ;
    c.widx = widx;
    push_cmd(c);
  endtask

  task automatic push_clear();
    splat_cmd_t c;
    c     = rand_cmd();
    c.act = vgbs_pkg::ACT_CLEAR;
    push_cmd(c);
  endtask

  // Raw noise; clears are kept rare since each one sweeps the whole RAM.
  task automatic push_noise();
    splat_cmd_t c;
    c = rand_cmd();
    if (c.act == vgbs_pkg::ACT_CLEAR && $urandom_range(0, 29) != 0)
      c.act = vgbs_pkg::ACT_READ;
    push_cmd(c);
  endtask

  function automatic logic signed [31:0] step_part(bit wild, bit main_axis);
    if (wild) return $urandom;
    if (main_axis)
      return ($urandom_range(0, 3) == 0) ? -rnd_int(1 << 15, 5 << 15)
                                         : rnd_int(1 << 15, 5 << 15);
    return rnd_int(-(1 << 14), 1 << 14);
  endfunction

  // One well-formed entity: origin, steps, small dims, then its flag bytes with
  // reads of nearby map rows mixed in. Some are cut short or run over.
  task automatic gen_entity();
    bit                 wild;
    logic signed [31:0] ox, oy, oz;
    int                 dx, dy, dz, wi;
    longint             nvox;
    wild = ($urandom_range(0, 9) == 0);
    if (wild) begin
      ox = $urandom;
      oy = $urandom;
      oz = $urandom;
    end else begin
      ox = rnd_int(-(2 << 16), 66 << 16);
      oy = rnd_int(-(2 << 16), 66 << 16);
      oz = rnd_int(-(2 << 16), 66 << 16);
    end
    push_load(vgbs_pkg::SEL_ORIGIN, ox, oy, oz);
    // a skipped step load keeps the previous entity's vector
    for (int v = 1; v <= 3; v++)
      if (v == 1 || $urandom_range(0, 3) != 0)
        push_load(3'(v), step_part(wild, v == 1), step_part(wild, v == 2),
                  step_part(wild, v == 3));
    dx = rnd_int(1, 6);
    dy = rnd_int(1, 5);
    dz = rnd_int(1, 4);
    if ($urandom_range(0, 11) == 0) dy = rnd_int(-3, 0);
    push_load(vgbs_pkg::SEL_DIMS, dx, dy, dz);
    nvox = longint'(dim_clip(dx)) * dim_clip(dy) * dim_clip(dz);
    if ($urandom_range(0, 5) == 0) nvox = rnd_int(0, int'(nvox) + 3);
    for (longint n = 0; n < nvox; n++) begin
      if ($urandom_range(0, 7) == 0) begin
        // with a 64-bit map width one word is one x row: word = z*H + y
        wi = int'(oz >>> 16) * MAP_H + int'(oy >>> 16) + rnd_int(-1, 2);
        push_read(wi[11:0]);
      end
      push_voxel(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 39) == 0) push_clear();
  endtask

  // Gap/stall pattern shared by both sides: short bursts, sometimes followed by
  // a quiet stretch with no gaps at all.
  function automatic bit draw_gap(inout int burst, inout int quiet);
    if (calm) return 1'b0;
    if (burst > 0) begin
      burst--;
      return 1'b1;
    end
    if (quiet > 0) begin
      quiet--;
      return 1'b0;
    end
    if ($urandom_range(0, 7) == 0) begin
      burst = $urandom_range(1, 11) - 1;
      if ($urandom_range(0, 3) == 0) quiet = $urandom_range(20, 60);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents queued beats at the falling edge, holds until taken
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      if (cmd_q.size() != 0 && !draw_gap(send_burst, send_quiet)) begin
        cur_cmd = cmd_q.pop_front();
        in_if.action        <= cur_cmd.act;
        in_if.vector_select <= cur_cmd.sel;
        in_if.vec_x         <= cur_cmd.vx;
        in_if.vec_y         <= cur_cmd.vy;
        in_if.vec_z         <= cur_cmd.vz;
        in_if.voxel_flags   <= cur_cmd.flags;
        in_if.word_index    <= cur_cmd.widx;
        in_if.valid         <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result-side backpressure
  always @(negedge clk) begin
    out_if.ready <= rst_n && !draw_gap(recv_burst, recv_quiet);
  end

  // ---------------------------------------------------------------------------
  // Accepted beats feed the predictor at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && cfg_if.valid && cfg_if.ready) begin
      occ_mask = cfg_if.data;
      n_masks++;
    end
    if (rst_n && in_if.valid && in_if.ready) begin
      pred_q.push_back(predict_beat(cur_cmd));
      n_beats++;
      case (cur_cmd.act)
        vgbs_pkg::ACT_LOAD:  n_loads++;
        vgbs_pkg::ACT_VOXEL: n_voxels++;
        vgbs_pkg::ACT_READ:  n_reads++;
        default:             n_clears++;
      endcase
      in_taken <= 1'b1;
    end else begin
      in_taken <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every result beat against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      fail_cnt++;
      if (fail_cnt <= 40)
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    splat_res_t w;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pred_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 40)
          $display("%0t ns: result beat with none expected, actual word %0h dirty %0h..%0h",
                   $time, out_if.map_word, out_if.dirty_min, out_if.dirty_max);
      end else begin
        w = pred_q.pop_front();
        n_checked++;
        if (w.bit_set) n_bits++;
        check_field("map_word", w.map_word, out_if.map_word);
        check_field("bit_set", w.bit_set, out_if.bit_set);
        check_field("entity_done", w.entity_done, out_if.entity_done);
        check_field("dirty_min", w.dirty_min, out_if.dirty_min);
        check_field("dirty_max", w.dirty_max, out_if.dirty_max);
      end
    end
  end

  // Watchdog
  int cycles;
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t ns: timeout, %0d beats still queued, %0d results outstanding",
               $time, cmd_q.size(), pred_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------
  // Idle means nothing queued, nothing on the bus and nothing outstanding.
  task automatic drain();
    do @(posedge clk);
    while (cmd_q.size() != 0 || in_if.valid || pred_q.size() != 0);
  endtask

  task automatic set_mask(logic [7:0] m);
    drain();
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= m;
    do @(posedge clk);
    while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    logic [7:0] m;
    // known values on every input from time zero
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.action        = vgbs_pkg::ACT_READ;
    in_if.vector_select = vgbs_pkg::SEL_ORIGIN;
    in_if.vec_x         = '0;
    in_if.vec_y         = '0;
    in_if.vec_z         = '0;
    in_if.voxel_flags   = '0;
    in_if.word_index    = '0;
    out_if.ready        = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.data         = '0;
    in_taken            = 1'b0;

    // predictor reset state
    map_wipe();
    foreach (ent_vec[v]) ent_vec[v] = '0;
    foreach (extent[a]) extent[a] = 0;
    walk_restart();
    occ_mask  = 8'h01;
    gen_total = 0;
    gen_left  = 0;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, reset mask value written explicitly.
    set_mask(8'h01);
    push_read(12'hFFF);                 // empty map, top word
    push_voxel(8'hFF);                  // nothing loaded: ignored, entity done
    push_load(vgbs_pkg::SEL_ORIGIN, 0, 0, 0);
    push_load(vgbs_pkg::SEL_STEP_I, 1 << 16, 0, 0);
    push_load(vgbs_pkg::SEL_STEP_J, 0, 1 << 16, 0);
    push_load(vgbs_pkg::SEL_STEP_K, 0, 0, 1 << 16);
    push_load(vgbs_pkg::SEL_DIMS, 2, 2, 2);       // 2x2x2 cube at the origin
    push_voxel(8'h01);
    push_voxel(8'h00);
    push_voxel(8'hFF);
    push_voxel(8'h02);                  // flag outside the mask
    push_voxel(8'h01);
    push_voxel(8'h80);
    push_voxel(8'h03);
    push_voxel(8'h01);                  // last voxel: entity done
    push_read(12'd0);
    push_read(12'd65);
    push_load(3'd7, 32'sh7FFF_FFFF, 0, 0);  // unknown select, no effect
    push_load(vgbs_pkg::SEL_DIMS, -5, 300, 2);    // negative count: nothing pending
    push_voxel(8'hFF);
    push_load(vgbs_pkg::SEL_DIMS, 300, 1, 1);     // stride saturates at the max dim
    push_load(vgbs_pkg::SEL_ORIGIN, 32'sh003F_FFFF, 63 << 16, 63 << 16);  // far corner
    push_load(vgbs_pkg::SEL_STEP_I, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
    push_voxel(8'hFF);                  // sets the last bit of the map
    push_voxel(8'hFF);                  // x clipped to max: outside the map
    push_read(12'hFFF);
    push_clear();
    push_read(12'hFFF);

    // Random part: several mask settings, the last one without any gaps.
    for (int ph = 0; ph < 5; ph++) begin
      m = (ph == 2) ? 8'($urandom_range(1, 254)) : MASK_PLAN[ph];
      set_mask(m);
      calm = (ph == 4);
      n_real = 0;
      while (n_real < PHASE_BEATS) begin
        if ($urandom_range(0, 6) == 0)
          repeat ($urandom_range(1, 3)) push_noise();
        else
          gen_entity();
      end
    end

    drain();
    repeat (SETTLE_TICKS) @(posedge clk);
    $display("Covered %0d beats: %0d loads, %0d voxels, %0d reads, %0d clears, %0d masks.",
             n_beats, n_loads, n_voxels, n_reads, n_clears, n_masks);
    $display("Checked %0d result beats, %0d map bits set, %0d mismatches.",
             n_checked, n_bits, fail_cnt);
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
